@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, word layout and the issue record that passes
// from the queue control to the result pipeline.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int DATA_W      = 32;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int FILL_W      = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [FUNC_W-1:0] OP_POP_BACK   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic                pop_ok;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill;
	} deq_issue_t;

endpackage

@@ rtl/core/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl: head and occupancy tracking of the circular store
// Decodes an accepted word, drives the RAM write or read address and updates
// the head index and the occupancy in the same cycle.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [deq_pkg::FUNC_W-1:0]    func,
	input  logic [deq_pkg::DATA_W-1:0]    value,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [deq_pkg::DATA_W-1:0]    ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	output deq_pkg::deq_issue_t           issue
);

	import deq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam logic [AW:0]      DEPTH_X = (AW + 1)'(DEPTH);
	localparam logic [OCC_W-1:0] FULL    = OCC_W'(DEPTH);
	localparam logic [AW-1:0]    LAST    = AW'(DEPTH - 1);

	logic [AW-1:0]    head_q;
	logic [OCC_W-1:0] occ_q;
	logic [AW-1:0]    head_d;
	logic [OCC_W-1:0] occ_d;
	logic             empty;
	logic             full;
	logic [AW:0]      back_sum;
	logic [AW-1:0]    back_slot;
	logic [AW:0]      last_sum;
	logic [AW-1:0]    last_slot;
	logic [AW-1:0]    head_inc;
	logic [AW-1:0]    head_dec;

	assign empty = (occ_q == '0);
	assign full  = (occ_q == FULL);

	// slot after the back: head + occupancy, wrapped once
	assign back_sum  = {1'b0, head_q} + (AW + 1)'(occ_q);
	assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : AW'(back_sum);
	// back slot itself: head + occupancy - 1
	assign last_sum  = {1'b0, head_q} + (AW + 1)'(occ_q - 1'b1);
	assign last_slot = (last_sum >= DEPTH_X) ? AW'(last_sum - DEPTH_X) : AW'(last_sum);
	assign head_inc  = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? LAST : head_q - 1'b1;

	always_comb begin
		head_d       = head_q;
		occ_d        = occ_q;
		ram_we       = 1'b0;
		ram_waddr    = back_slot;
		ram_re       = 1'b0;
		ram_raddr    = head_q;
		issue.pop_ok = 1'b0;
		issue.status = ST_OK;
		case (func)
			OP_PUSH_FRONT: begin
				if (full) begin
					issue.status = ST_OVERFLOW;
				end else begin
					head_d    = head_dec;
					occ_d     = occ_q + 1'b1;
					ram_we    = accept;
					ram_waddr = head_dec;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					issue.status = ST_OVERFLOW;
				end else begin
					occ_d  = occ_q + 1'b1;
					ram_we = accept;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					issue.status = ST_UNDERFLOW;
				end else begin
					head_d       = head_inc;
					occ_d        = occ_q - 1'b1;
					ram_re       = accept;
					issue.pop_ok = 1'b1;
				end
			end
			default: begin
				if (empty) begin
					issue.status = ST_UNDERFLOW;
				end else begin
					occ_d        = occ_q - 1'b1;
					ram_re       = accept;
					ram_raddr    = last_slot;
					issue.pop_ok = 1'b1;
				end
			end
		endcase
		issue.fill = FILL_W'(occ_d);
	end

	assign ram_wdata = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			occ_q  <= occ_d;
		end
	end

endmodule

@@ rtl/core/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of 32-bit words in a circular RAM
// Result path: RAM read register (with the issue record), then output reg.
// Throughput: one word per cycle when the output is not stalled; the single
//   RAM port pair sets the pace: each word does at most one write or read.
// Reset: head and occupancy clear to zero; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// func [1:0], value [33:2], zero fill [39:34]
	input  logic [deq_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// popped_value [31:0], status [33:32], fill_count [38:34], zero [39]
	output logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                s_accept;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;
	deq_issue_t          issue;
	logic                valid_s1;
	deq_issue_t          issue_s1;
	logic                out_load;
	logic                m_tvalid_q;
	logic [DATA_W-1:0]   popped_q;
	logic [STATUS_W-1:0] status_q;
	logic [FILL_W-1:0]   fill_q;

	assign s_accept = s_tvalid && s_tready;
	assign out_load = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || out_load;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.func      (s_tdata[FUNC_W-1:0]),
		.value     (s_tdata[FUNC_W +: DATA_W]),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.issue     (issue)
	);

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// RAM read data holds while stage 1 stalls: no new read is issued then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			issue_s1 <= issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			popped_q <= issue_s1.pop_ok ? ram_rdata : '0;
			status_q <= issue_s1.status;
			fill_q   <= issue_s1.fill;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - DATA_W - STATUS_W - FILL_W){1'b0}},
		fill_q, status_q, popped_q};

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == ST_UNDERFLOW |->
			m_tdata[38:34] == '0 && m_tdata[31:0] == '0)
		else $error("underflow result with nonzero fill or word");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] == ST_OVERFLOW |-> m_tdata[31:0] == '0)
		else $error("overflow result carries a popped word");

	a_accept_stage: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted word lost before result stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1 && $stable(issue_s1))
		else $error("pending result overwritten during stall");

endmodule
